@@ rtl/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// non-overlapping implication (|=>) checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ rtl/dagts_pkg.sv @@
// package: action codes and shared types for the dag store
`timescale 1ns / 1ps
package dagts_pkg;
    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_QEDGE  = 3'd2;
    localparam logic [2:0] ACT_QPATH  = 3'd3;
    localparam logic [2:0] ACT_SORT   = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] from_node;
        logic [3:0] to_node;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic       answer;
        logic [3:0] order_node;
        logic       last;
    } t_out_item;
endpackage

@@ rtl/dagts_if.sv @@
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface dagts_in_if;
    logic valid;
    logic ready;
    dagts_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dagts_out_if;
    logic valid;
    logic ready;
    dagts_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dag_edge_store_topo_sort_core.sv @@
// top level: adjacency matrix store with reachability and kahn sort sequencer
`timescale 1ns / 1ps
// dag edge store with topological sort
// channels: in_ch (action, from_node, to_node) and out_ch (status, answer,
// order_node, last), both valid/ready; a transfer happens when both are high
// cfg: i_cfg_we / i_cfg_wdata write node_count; user: only while idle, not enforced
// one item at a time: in_ch.ready is high only in idle with the result register empty
// remove, edge query and rejects: the input is registered, decided in S_CHECK and
// loaded into the result register through S_OUT; the next input transfer can follow
// only after the result transfer, once the sequencer is back in idle
// add and path query: a check state, then passes over the MAX_NODES adjacency rows
// (one row at a time) until a pass adds nothing (up to about MAX_NODES passes),
// then the result is loaded through S_OUT
// sort: indegree counting over MAX_NODES columns (one column per cycle), queue fill
// over MAX_NODES rows, then per dequeued node a pop, a scan of its MAX_NODES-entry
// row and an emit, which outputs that node
// the row scan checks one adjacency entry and its indegree counter per cycle
// a stalled receiver holds the sequencer in its emit state, nothing is lost
// reset (synchronous, active low) clears the matrix (flip-flops), sets node_count
// to 16 and returns to idle
module dag_edge_store_topo_sort_core #(
    parameter int MAX_NODES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    dagts_in_if.sink   in_ch,
    dagts_out_if.source out_ch
);
    localparam int NB  = (MAX_NODES > 16) ? 16 : MAX_NODES;  // usable nodes
    localparam int IW  = $clog2(MAX_NODES);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_REACH = 10'b0000000100,
        S_DEG   = 10'b0000001000,
        S_FILL  = 10'b0000010000,
        S_POP   = 10'b0000100000,
        S_SCAN  = 10'b0001000000,
        S_EMIT  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [MAX_NODES-1:0] r_adj [MAX_NODES];
    logic [4:0]  r_ncfg;
    logic [2:0]  r_act;
    logic [3:0]  r_s, r_t;
    logic [MAX_NODES-1:0] r_vis, n_vis;
    logic        r_grew, n_grew;
    logic [IW-1:0] r_row, n_row;
    logic [4:0]  r_deg [MAX_NODES];
    logic [3:0]  r_q [16];
    logic [4:0]  r_head, n_head, r_tail, n_tail;
    logic [3:0]  r_x, n_x;
    logic        r_ovalid, n_ovalid;
    dagts_pkg::t_out_item r_odata, n_odata;
    logic        r_emitted, n_emitted;

    // array write strobes from the sequencer
    logic        w_adj_we, w_adj_val;
    logic        w_deg_we;
    logic [4:0]  w_deg_val;
    logic        w_q_we;

    // active node count, clamped
    logic [4:0] w_n;
    always_comb begin
        w_n = r_ncfg;
        if (w_n == 5'd0) w_n = 5'd1;
        if (w_n > 5'(NB)) w_n = 5'(NB);
    end

    logic w_valid;
    assign w_valid = ({1'b0, r_s} < w_n) && ({1'b0, r_t} < w_n);
    logic w_edge;
    assign w_edge = r_adj[IW'(r_s)][IW'(r_t)];
    logic [MAX_NODES-1:0] w_keep;
    always_comb begin
        for (int k = 0; k < MAX_NODES; k++) w_keep[k] = (k < 32'(w_n));
    end
    logic w_rowlast;
    assign w_rowlast = (r_row == IW'(MAX_NODES - 1));
    logic w_inrow;  // current row index within active set
    assign w_inrow = ({{(32-IW){1'b0}}, r_row} < 32'(w_n));

    // column r_row restricted to active rows
    logic [MAX_NODES-1:0] w_col;
    always_comb begin
        for (int k = 0; k < MAX_NODES; k++) w_col[k] = r_adj[k][r_row] & w_keep[k];
    end

    // reachability step for the current row; add walks all stored rows unmasked
    logic [MAX_NODES-1:0] w_reach_row;
    assign w_reach_row = r_adj[r_row] &
                         ((r_act == dagts_pkg::ACT_ADD) ? {MAX_NODES{1'b1}} : w_keep);
    logic w_grow;
    assign w_grow = r_vis[r_row] && (r_act == dagts_pkg::ACT_ADD || w_inrow)
                    && ((w_reach_row & ~r_vis) != '0);

    logic w_in_ready;
    assign w_in_ready = (r_state == S_IDLE) && !r_ovalid;
    logic w_take;
    assign w_take = in_ch.valid && w_in_ready;

    assign in_ch.ready  = w_in_ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    always_comb begin
        n_state   = r_state;
        n_vis     = r_vis;
        n_grew    = r_grew;
        n_row     = r_row;
        n_head    = r_head;
        n_tail    = r_tail;
        n_x       = r_x;
        n_odata   = r_odata;
        n_emitted = r_emitted;
        n_ovalid  = r_ovalid && !out_ch.ready;
        w_adj_we  = 1'b0;
        w_adj_val = 1'b0;
        w_deg_we  = 1'b0;
        w_deg_val = 5'd0;
        w_q_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_take) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_odata = '{status: 1'b1, answer: 1'b0, order_node: 4'd0, last: 1'b1};
                n_state = S_OUT;
                n_row   = '0;
                n_grew  = 1'b0;
                case (r_act)
                    dagts_pkg::ACT_ADD: begin
                        if (w_valid && r_s != r_t) begin
                            if (w_edge) n_odata.status = 1'b0;
                            else begin
                                n_vis   = MAX_NODES'(1) << r_t;
                                n_state = S_REACH;
                            end
                        end
                    end
                    dagts_pkg::ACT_REMOVE: begin
                        if (w_valid && w_edge) begin
                            w_adj_we       = 1'b1;
                            w_adj_val      = 1'b0;
                            n_odata.status = 1'b0;
                        end
                    end
                    dagts_pkg::ACT_QEDGE: begin
                        if (w_valid) begin
                            n_odata.status = 1'b0;
                            n_odata.answer = w_edge;
                        end
                    end
                    dagts_pkg::ACT_QPATH: begin
                        if (w_valid) begin
                            n_vis   = MAX_NODES'(1) << r_s;
                            n_state = S_REACH;
                        end
                    end
                    dagts_pkg::ACT_SORT: begin
                        n_tail    = '0;
                        n_head    = '0;
                        n_emitted = 1'b0;
                        n_state   = S_DEG;
                    end
                    default: ;
                endcase
            end
            S_REACH: begin
                // one row per cycle, passes repeat until the set stops growing
                if (w_grow) begin
                    n_vis  = r_vis | w_reach_row;
                    n_grew = 1'b1;
                end
                n_row = r_row + 1'b1;
                if (w_rowlast) begin
                    if (r_grew || w_grow) begin
                        n_grew = 1'b0;
                        n_row  = '0;
                    end else begin
                        n_state = S_OUT;
                        if (r_act == dagts_pkg::ACT_ADD) begin
                            if (!r_vis[r_s]) begin
                                w_adj_we       = 1'b1;
                                w_adj_val      = 1'b1;
                                n_odata.status = 1'b0;
                            end
                        end else begin
                            n_odata.status = 1'b0;
                            n_odata.answer = r_vis[r_t];
                        end
                    end
                end
            end
            S_DEG: begin
                // indegree of column r_row over active rows
                w_deg_we  = 1'b1;
                w_deg_val = 5'($countones(w_col));
                n_row     = r_row + 1'b1;
                if (w_rowlast) begin
                    n_row   = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (w_inrow && r_deg[r_row] == 5'd0) begin
                    w_q_we = 1'b1;
                    n_tail = r_tail + 5'd1;
                end
                n_row = r_row + 1'b1;
                if (w_rowlast) n_state = S_POP;
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    if (!r_emitted) begin
                        n_odata = '{status: 1'b1, answer: 1'b0,
                                    order_node: 4'd0, last: 1'b1};
                        n_state = S_OUT;
                    end else n_state = S_IDLE;
                end else begin
                    n_x     = r_q[r_head[3:0]];
                    n_head  = r_head + 5'd1;
                    n_row   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_inrow && r_adj[IW'(r_x)][r_row] && r_deg[r_row] != 5'd0) begin
                    w_deg_we  = 1'b1;
                    w_deg_val = r_deg[r_row] - 5'd1;
                    if (r_deg[r_row] == 5'd1) begin
                        w_q_we = 1'b1;
                        n_tail = r_tail + 5'd1;
                    end
                end
                n_row = r_row + 1'b1;
                if (w_rowlast) n_state = S_EMIT;
            end
            S_EMIT: begin
                // queue now final for this node: last when it is empty
                if (!r_ovalid || out_ch.ready) begin
                    n_odata   = '{status: 1'b0, answer: 1'b0, order_node: r_x,
                                  last: (r_head == r_tail)};
                    n_ovalid  = 1'b1;
                    n_emitted = 1'b1;
                    n_state   = S_POP;
                end
            end
            S_OUT: begin
                if (!r_ovalid || out_ch.ready) begin
                    n_ovalid = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ncfg   <= 5'd16;
            r_ovalid <= 1'b0;
            for (int k = 0; k < MAX_NODES; k++) r_adj[k] <= '0;
        end else begin
            if (i_cfg_we) r_ncfg <= i_cfg_wdata;
            if (w_take) begin
                r_act <= in_ch.data.action;
                r_s   <= in_ch.data.from_node;
                r_t   <= in_ch.data.to_node;
            end
            if (w_adj_we) r_adj[IW'(r_s)][IW'(r_t)] <= w_adj_val;
            r_state   <= n_state;
            r_vis     <= n_vis;
            r_grew    <= n_grew;
            r_row     <= n_row;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_x       <= n_x;
            r_odata   <= n_odata;
            r_emitted <= n_emitted;
            r_ovalid  <= n_ovalid;
        end
    end

    // scratch stores: indegree counters and node queue
    always_ff @(posedge i_clk) begin
        if (w_deg_we) r_deg[r_row] <= w_deg_val;
        if (w_q_we) r_q[r_tail[3:0]] <= 4'(r_row);
    end
endmodule

@@ rtl/dagts_checker.sv @@
// port checker for the dag store, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dagts_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_status,
    input logic i_out_answer,
    input logic [3:0] i_out_order
);
    `CHK_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `CHK_IMPL(a_rej_clean, i_clk, i_rst_n, i_out_valid && i_out_status, !i_out_answer && i_out_order == 4'd0)
    `CHK_IMPL(a_no_take_while_out, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_out_valid)
endmodule

bind dag_edge_store_topo_sort_core dagts_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_out_status(out_ch.data.status), .i_out_answer(out_ch.data.answer),
    .i_out_order(out_ch.data.order_node)
);

@@ bench/dagts_checker.sv @@
// checker: predicts dag store results from observed transfers and compares them
`timescale 1ns / 1ps
module dagts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    dagts_in_if         in_mon,
    dagts_out_if        out_mon,
    output int          o_fail_count,
    output int          o_pending
);
    logic [15:0] adj_rows [16];
    logic [4:0]  node_cnt;
    dagts_pkg::t_out_item expected_q [$];

    function automatic int active_count();
        if (node_cnt == 5'd0) return 1;
        if (node_cnt > 5'd16) return 16;
        return int'(node_cnt);
    endfunction

    // nodes reachable from src over rows below lim, targets limited to keep
    function automatic logic [15:0] reach_set(input logic [3:0] src, input int lim,
                                              input logic [15:0] keep);
        logic [15:0] seen;
        logic [15:0] grown;
        seen = 16'd1 << src;
        for (int p = 0; p <= 16; p++) begin
            grown = seen;
            for (int v = 0; v < lim; v++)
                if (seen[v]) grown |= adj_rows[v] & keep;
            if (grown == seen) break;
            seen = grown;
        end
        return seen;
    endfunction

    function automatic dagts_pkg::t_out_item single(input logic st, input logic ans);
        dagts_pkg::t_out_item r;
        r.status = st;
        r.answer = ans;
        r.order_node = 4'd0;
        r.last = 1'b1;
        return r;
    endfunction

    // kahn order over active nodes, pushed straight into the expected store
    function automatic void predict_sort(input int n);
        int deg [16];
        logic [3:0] fifo [16];
        int head, tail, d;
        logic [3:0] x;
        dagts_pkg::t_out_item r;
        head = 0;
        tail = 0;
        for (int v = 0; v < n; v++) begin
            d = 0;
            for (int u = 0; u < n; u++)
                if (adj_rows[u][v]) d++;
            deg[v] = d;
        end
        for (int v = 0; v < n; v++)
            if (deg[v] == 0) begin
                fifo[tail] = v[3:0];
                tail++;
            end
        while (head < tail) begin
            x = fifo[head];
            head++;
            r = '0;
            r.order_node = x;
            r.last = (head == tail);
            for (int v = 0; v < n; v++)
                if (adj_rows[x][v] && deg[v] > 0) begin
                    deg[v]--;
                    if (deg[v] == 0) begin
                        fifo[tail] = v[3:0];
                        tail++;
                        r.last = 1'b0;
                    end
                end
            expected_q.push_back(r);
        end
        if (tail == 0) expected_q.push_back(single(1'b1, 1'b0));
    endfunction

    function automatic void predict_item(input dagts_pkg::t_in_item it);
        int n;
        logic [15:0] keep;
        logic ok;
        logic [15:0] fwd;
        logic [15:0] pth;
        n = active_count();
        keep = (n == 16) ? 16'hffff : ((16'd1 << n) - 16'd1);
        ok = (it.from_node < n) && (it.to_node < n);
        fwd = reach_set(it.to_node, 16, 16'hffff);
        pth = reach_set(it.from_node, n, keep);
        case (it.action)
            dagts_pkg::ACT_ADD: begin
                if (!ok || it.from_node == it.to_node)
                    expected_q.push_back(single(1'b1, 1'b0));
                else if (adj_rows[it.from_node][it.to_node])
                    expected_q.push_back(single(1'b0, 1'b0));
                else if (fwd[it.from_node])
                    expected_q.push_back(single(1'b1, 1'b0));
                else begin
                    adj_rows[it.from_node][it.to_node] = 1'b1;
                    expected_q.push_back(single(1'b0, 1'b0));
                end
            end
            dagts_pkg::ACT_REMOVE: begin
                if (!ok || !adj_rows[it.from_node][it.to_node])
                    expected_q.push_back(single(1'b1, 1'b0));
                else begin
                    adj_rows[it.from_node][it.to_node] = 1'b0;
                    expected_q.push_back(single(1'b0, 1'b0));
                end
            end
            dagts_pkg::ACT_QEDGE:
                expected_q.push_back(ok ? single(1'b0, adj_rows[it.from_node][it.to_node])
                                        : single(1'b1, 1'b0));
            dagts_pkg::ACT_QPATH:
                expected_q.push_back(ok ? single(1'b0, pth[it.to_node])
                                        : single(1'b1, 1'b0));
            dagts_pkg::ACT_SORT:
                predict_sort(n);
            default:
                expected_q.push_back(single(1'b1, 1'b0));
        endcase
    endfunction

    always @(posedge i_clk) begin
        dagts_pkg::t_out_item want;
        dagts_pkg::t_out_item got;
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) adj_rows[i] = '0;
            node_cnt = 5'd16;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) node_cnt = i_cfg_wdata;
            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer: %p", got);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.answer !== want.answer) begin
                        $error("answer: expected %0d, got %0d", want.answer, got.answer);
                        o_fail_count++;
                    end
                    if (got.order_node !== want.order_node) begin
                        $error("order_node: expected %0d, got %0d",
                               want.order_node, got.order_node);
                        o_fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) predict_item(in_mon.data);
        end
        o_pending = expected_q.size();
    end
endmodule

@@ bench/tb.sv @@
// testbench top: stimulus, receiver stalls, config phases and verdict
`timescale 1ns / 1ps
module tb;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;
    int         fail_count;
    int         pending;
    int         cycle_cnt;

    // sender burst state
    int  burst_left;
    // receiver: stall style per phase and a one-shot long hold request
    int  stall_style;
    bit  hold_req;
    int  hold_left;
    int  cur_nodes;

    dagts_in_if  in_ch ();
    dagts_out_if out_ch ();

    dag_edge_store_topo_sort_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    dagts_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: ready pattern changes per phase, long hold once to back up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            out_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_req = 1'b0;
        end else begin
            case (stall_style)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 4) == 0);
                default: out_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // one input transfer; called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [2:0] act, input logic [3:0] src,
                             input logic [3:0] dst);
        dagts_pkg::t_in_item it;
        bit done;
        it.action = act;
        it.from_node = src;
        it.to_node = dst;
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = in_ch.ready;
        end
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of burst: drop valid for a random gap, sometimes none at all
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    // wait for all results, then change node_count while idle
    task automatic set_nodes(input logic [4:0] val);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (val == 5'd0) cur_nodes = 1;
        else if (val > 5'd16) cur_nodes = 16;
        else cur_nodes = val;
    endtask

    function automatic logic [3:0] pick_node();
        if ($urandom_range(0, 4) != 0) return 4'($urandom_range(0, cur_nodes - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic random_items(input int count);
        int w;
        logic [2:0] act;
        for (int i = 0; i < count; i++) begin
            w = $urandom_range(0, 99);
            // mostly adds so the graph grows deep enough to make sorts and paths interesting
            if (w < 40) act = dagts_pkg::ACT_ADD;
            else if (w < 55) act = dagts_pkg::ACT_REMOVE;
            else if (w < 67) act = dagts_pkg::ACT_QEDGE;
            else if (w < 85) act = dagts_pkg::ACT_QPATH;
            else if (w < 95) act = dagts_pkg::ACT_SORT;
            else act = 3'($urandom_range(5, 7));
            send_item(act, pick_node(), pick_node());
        end
    endtask

    initial begin
        logic [4:0] node_plan [7];
        node_plan = '{5'd5, 5'd1, 5'd0, 5'd31, 5'd9, 5'd2, 5'd16};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 5'd0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cycle_cnt = 0;
        burst_left = 0;
        stall_style = 0;
        hold_req = 1'b0;
        hold_left = 0;
        cur_nodes = 16;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: chain, cycle reject, duplicate, self loop, extremes, queries, sort
        send_item(dagts_pkg::ACT_SORT, 4'd0, 4'd0);
        send_item(dagts_pkg::ACT_ADD, 4'd0, 4'd1);
        send_item(dagts_pkg::ACT_ADD, 4'd1, 4'd2);
        send_item(dagts_pkg::ACT_ADD, 4'd2, 4'd0);
        send_item(dagts_pkg::ACT_ADD, 4'd0, 4'd1);
        send_item(dagts_pkg::ACT_ADD, 4'd3, 4'd3);
        send_item(dagts_pkg::ACT_ADD, 4'd15, 4'd0);
        send_item(dagts_pkg::ACT_ADD, 4'd2, 4'd15);
        send_item(dagts_pkg::ACT_QEDGE, 4'd0, 4'd1);
        send_item(dagts_pkg::ACT_QEDGE, 4'd1, 4'd0);
        send_item(dagts_pkg::ACT_QPATH, 4'd15, 4'd2);
        send_item(dagts_pkg::ACT_QPATH, 4'd2, 4'd0);
        send_item(dagts_pkg::ACT_QPATH, 4'd7, 4'd7);
        send_item(dagts_pkg::ACT_REMOVE, 4'd1, 4'd2);
        send_item(dagts_pkg::ACT_REMOVE, 4'd1, 4'd2);
        send_item(dagts_pkg::ACT_SORT, 4'd15, 4'd15);
        send_item(3'd5, 4'd0, 4'd0);
        send_item(3'd6, 4'd15, 4'd15);
        send_item(3'd7, 4'd9, 4'd6);
        // shrink: edges to node 15 become hidden, out-of-range queries reject
        set_nodes(5'd3);
        send_item(dagts_pkg::ACT_QEDGE, 4'd15, 4'd0);
        send_item(dagts_pkg::ACT_QPATH, 4'd0, 4'd15);
        send_item(dagts_pkg::ACT_ADD, 4'd2, 4'd0);
        send_item(dagts_pkg::ACT_SORT, 4'd0, 4'd0);
        set_nodes(5'd16);
        send_item(dagts_pkg::ACT_QPATH, 4'd15, 4'd1);

        stall_style = 1;
        random_items(115);
        // long receiver hold while the sender keeps offering a sort and random items
        hold_req = 1'b1;
        stall_style = 0;
        send_item(dagts_pkg::ACT_SORT, 4'd0, 4'd0);
        random_items(40);
        foreach (node_plan[k]) begin
            set_nodes(node_plan[k]);
            stall_style = k % 4;
            random_items(node_plan[k] < 5'd3 ? 20 : 35);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ dag_edge_store_topo_sort_core.f @@
+incdir+rtl
rtl/dagts_pkg.sv
rtl/dagts_if.sv
rtl/dag_edge_store_topo_sort_core.sv
rtl/dagts_checker.sv
bench/dagts_checker.sv
bench/tb.sv
